[hw/rtl/ipsl_pkg.sv]
// Shared types and constants for the incremental PID speed loop.
package ipsl_pkg;

  localparam int IPSL_CHANNELS = 4;

  localparam int CH_W       = 2;
  localparam int SPD_W      = 16;
  localparam int ERR_W      = 17;
  localparam int DIF_W      = 18;
  localparam int GAIN_W     = 16;
  localparam int PER_W      = 8;
  localparam int DRV_W      = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam int MUL_A_W = 34;
  localparam int MUL_W   = MUL_A_W + DIF_W;
  localparam int PROD_W  = 34;
  localparam int IPROD_W = 41;
  localparam int SUM_W   = 44;

  localparam logic [GAIN_W-1:0] GAIN_P_RST = 16'd11008;
  localparam logic [GAIN_W-1:0] GAIN_I_RST = 16'd205;
  localparam logic [GAIN_W-1:0] GAIN_D_RST = 16'd2304;
  localparam logic [PER_W-1:0]  PERIOD_RST = 8'd5;
  localparam logic signed [DRV_W-1:0] LIMIT_HIGH_RST = 24'sd15360;
  localparam logic signed [DRV_W-1:0] LIMIT_LOW_RST  = 24'sd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P     = 3'd0,
    REG_GAIN_I     = 3'd1,
    REG_GAIN_D     = 3'd2,
    REG_PERIOD     = 3'd3,
    REG_LIMIT_HIGH = 3'd4,
    REG_LIMIT_LOW  = 3'd5
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_MUL_P,
    S_MUL_I1,
    S_MUL_I2,
    S_MUL_D,
    S_DIV_GO,
    S_DIV_WAIT,
    S_SUB,
    S_COMMIT
  } ctrl_state_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_P,
    MUL_I1,
    MUL_I2,
    MUL_D
  } mul_op_t;

  typedef struct packed {
    logic    load_in;
    logic    load_hist;
    mul_op_t mul_op;
    logic    div_start;
    logic    sub_d;
    logic    commit;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic ch_ok;
  } dp_sts_t;

endpackage

[hw/rtl/ipsl_divider.sv]
// Bit-serial signed-by-unsigned divider with truncation toward zero.
module ipsl_divider (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic signed [ipsl_pkg::PROD_W-1:0]    num,
  input  logic        [ipsl_pkg::PER_W-1:0]     den,
  output logic                                  done,
  output logic signed [ipsl_pkg::PROD_W-1:0]    quot
);
  import ipsl_pkg::*;

  localparam int CNT_W = $clog2(PROD_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(PROD_W - 1);

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                neg_r;
  logic [PROD_W-1:0]   dq_r;
  logic [PER_W-1:0]    rem_r;
  logic [PER_W-1:0]    den_r;

  logic [PROD_W-1:0]   mag;
  logic [PER_W:0]      r2;
  logic [PER_W+1:0]    diff;
  logic                ge;

  assign mag  = num[PROD_W-1] ? PROD_W'(-num) : PROD_W'(num);
  assign r2   = {rem_r, dq_r[PROD_W-1]};
  assign diff = {1'b0, r2} - {2'b00, den_r};
  assign ge   = !diff[PER_W+1];

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = done_r;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = (den != '0);
      done_nxt = (den == '0);
      cnt_nxt  = '0;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      rem_r <= '0;
      neg_r <= (den != '0) && num[PROD_W-1];
      dq_r  <= (den != '0) ? mag : '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[PER_W-1:0] : r2[PER_W-1:0];
      dq_r  <= {dq_r[PROD_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = neg_r ? -signed'(dq_r) : signed'(dq_r);

  a_busy_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !done_r)
    else $error("divider reports done while still iterating");

  a_last_step: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !start && cnt_r == LAST |=> done_r && !busy_r)
    else $error("divider did not finish after its last step");

  a_zero_den: assert property (@(posedge clk) disable iff (!rst_n)
    start && den == '0 |=> done_r && quot == '0)
    else $error("zero divisor must give a zero quotient at once");

endmodule

[hw/rtl/ipsl_datapath.sv]
// Datapath: configuration registers, channel history, shared multiplier, divider and clamp.
module ipsl_datapath #(
  parameter int CHANNELS = ipsl_pkg::IPSL_CHANNELS
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic        [ipsl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic        [ipsl_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic        [ipsl_pkg::CH_W-1:0]       in_channel,
  input  logic signed [ipsl_pkg::SPD_W-1:0]      in_target_speed,
  input  logic signed [ipsl_pkg::SPD_W-1:0]      in_measured_speed,
  input  ipsl_pkg::dp_cmd_t                      cmd,
  output ipsl_pkg::dp_sts_t                      sts,
  output logic        [ipsl_pkg::CH_W-1:0]       out_channel_out,
  output logic signed [ipsl_pkg::DRV_W-1:0]      out_drive
);
  import ipsl_pkg::*;

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Configuration.
  logic        [GAIN_W-1:0] gain_p_r, gain_i_r, gain_d_r;
  logic        [PER_W-1:0]  period_r;
  logic signed [DRV_W-1:0]  lim_hi_r, lim_lo_r;

  // Latched input word.
  logic        [CH_W-1:0]   ch_r;
  logic signed [SPD_W-1:0]  tgt_r, meas_r;

  // Per-channel history.
  logic signed [ERR_W-1:0]  perr_r [CHANNELS];
  logic signed [SPD_W-1:0]  pm_r   [CHANNELS];
  logic signed [SPD_W-1:0]  ppm_r  [CHANNELS];
  logic signed [DRV_W-1:0]  dacc_r [CHANNELS];

  // Working registers.
  logic signed [ERR_W-1:0]  err_r;
  logic signed [DIF_W-1:0]  de_r, dm_r;
  logic signed [DRV_W-1:0]  dprev_r;
  logic signed [PROD_W-1:0] pprod_r, dprod_r;
  logic signed [IPROD_W-1:0] iprod_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic        [CH_W-1:0]   out_ch_r;
  logic signed [DRV_W-1:0]  out_drive_r;

  logic                     ch_ok;
  logic                     div_done;
  logic        [IDX_W-1:0]  idx;
  logic signed [ERR_W-1:0]  err_w;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [DIF_W-1:0]  mul_b;
  logic signed [MUL_W-1:0]  mul_w;
  logic signed [PROD_W-1:0] dq;
  logic signed [SUM_W-1:0]  zsum, hi, lo, c1, c2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r <= GAIN_P_RST;
      gain_i_r <= GAIN_I_RST;
      gain_d_r <= GAIN_D_RST;
      period_r <= PERIOD_RST;
      lim_hi_r <= LIMIT_HIGH_RST;
      lim_lo_r <= LIMIT_LOW_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GAIN_P:     gain_p_r <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_I:     gain_i_r <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_D:     gain_d_r <= cfg_wdata[GAIN_W-1:0];
        REG_PERIOD:     period_r <= cfg_wdata[PER_W-1:0];
        REG_LIMIT_HIGH: lim_hi_r <= signed'(cfg_wdata[DRV_W-1:0]);
        REG_LIMIT_LOW:  lim_lo_r <= signed'(cfg_wdata[DRV_W-1:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      ch_r   <= in_channel;
      tgt_r  <= in_target_speed;
      meas_r <= in_measured_speed;
    end
  end

  assign ch_ok = (int'(ch_r) < CHANNELS);
  assign idx   = ch_ok ? IDX_W'(ch_r) : '0;
  assign err_w = ERR_W'(tgt_r) - ERR_W'(meas_r);

  // The second difference of the measurement fits 18 bits even when the
  // intermediate sums wrap.
  always_ff @(posedge clk) begin
    if (cmd.load_hist) begin
      err_r   <= err_w;
      de_r    <= DIF_W'(err_w) - DIF_W'(perr_r[idx]);
      dm_r    <= DIF_W'(meas_r) - (DIF_W'(pm_r[idx]) <<< 1) + DIF_W'(ppm_r[idx]);
      dprev_r <= dacc_r[idx];
    end
  end

  always_comb begin
    case (cmd.mul_op)
      MUL_P: begin
        mul_a = signed'(MUL_A_W'(gain_p_r));
        mul_b = de_r;
      end
      MUL_I1: begin
        mul_a = signed'(MUL_A_W'(gain_i_r));
        mul_b = DIF_W'(err_r);
      end
      MUL_I2: begin
        mul_a = iprod_r[MUL_A_W-1:0];
        mul_b = signed'(DIF_W'(period_r));
      end
      MUL_D: begin
        mul_a = signed'(MUL_A_W'(gain_d_r));
        mul_b = dm_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_w = MUL_W'(mul_a) * MUL_W'(mul_b);

  always_ff @(posedge clk) begin
    case (cmd.mul_op)
      MUL_P:  pprod_r <= mul_w[PROD_W-1:0];
      MUL_I1: iprod_r <= mul_w[IPROD_W-1:0];
      MUL_I2: iprod_r <= mul_w[IPROD_W-1:0];
      MUL_D: begin
        dprod_r <= mul_w[PROD_W-1:0];
        sum_r   <= SUM_W'(dprev_r) + SUM_W'(pprod_r) + SUM_W'(iprod_r);
      end
      default: ;
    endcase
    if (cmd.sub_d) begin
      sum_r <= sum_r - SUM_W'(dq);
    end
  end

  ipsl_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (dprod_r),
    .den   (period_r),
    .done  (div_done),
    .quot  (dq)
  );

  assign zsum = (tgt_r == '0) ? '0 : sum_r;
  assign hi   = SUM_W'(lim_hi_r);
  assign lo   = SUM_W'(lim_lo_r);
  assign c1   = (zsum > hi) ? hi : zsum;
  assign c2   = (c1 < lo) ? lo : c1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        perr_r[i] <= '0;
        pm_r[i]   <= '0;
        ppm_r[i]  <= '0;
        dacc_r[i] <= '0;
      end
    end else if (cmd.commit && ch_ok) begin
      perr_r[idx] <= err_r;
      ppm_r[idx]  <= pm_r[idx];
      pm_r[idx]   <= meas_r;
      dacc_r[idx] <= c2[DRV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_ch_r    <= ch_r;
      out_drive_r <= ch_ok ? c2[DRV_W-1:0] : '0;
    end
  end

  assign sts             = '{div_done: div_done, ch_ok: ch_ok};
  assign out_channel_out = out_ch_r;
  assign out_drive       = out_drive_r;

endmodule

[hw/rtl/ipsl_ctrl.sv]
// Sequencer for the speed loop: steps the datapath and owns both handshakes.
module ipsl_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output ipsl_pkg::dp_cmd_t cmd,
  input  ipsl_pkg::dp_sts_t sts
);
  import ipsl_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.mul_op    = MUL_NONE;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.load_hist = 1'b1;
        state_nxt     = sts.ch_ok ? S_MUL_P : S_COMMIT;
      end
      S_MUL_P: begin
        cmd.mul_op = MUL_P;
        state_nxt  = S_MUL_I1;
      end
      S_MUL_I1: begin
        cmd.mul_op = MUL_I1;
        state_nxt  = S_MUL_I2;
      end
      S_MUL_I2: begin
        cmd.mul_op = MUL_I2;
        state_nxt  = S_MUL_D;
      end
      S_MUL_D: begin
        cmd.mul_op = MUL_D;
        state_nxt  = S_DIV_GO;
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (sts.div_done) begin
          state_nxt = S_SUB;
        end
      end
      S_SUB: begin
        cmd.sub_d = 1'b1;
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (!out_valid_r || out_ready) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

  a_accept_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_LOAD)
    else $error("accepted word did not start a computation");

  a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("committed result is not presented");

  a_div_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV_WAIT && !sts.div_done |=> state_r == S_DIV_WAIT)
    else $error("left the divider wait before the quotient was ready");

endmodule

[hw/rtl/incremental_pid_speed_loop_top.sv]
// Top level of the multi-channel incremental PID speed loop.
// Latency is set by the 34-step bit-serial divider for the derivative term; it is
// shorter when period_ms is zero, and shorter still for a channel number of CHANNELS
// or above, which skips the arithmetic. A new word is accepted only once the previous
// one is committed; the four products share one multiplier, one per cycle.
// Reset (rst_n, synchronous, active low) restores the register defaults, clears all
// channel history and drive accumulators, and empties the output register.
module incremental_pid_speed_loop_top #(
  parameter int CHANNELS = ipsl_pkg::IPSL_CHANNELS
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // Configuration write port; writes are only expected while the loop is idle.
  input  logic                                   cfg_we,
  input  logic        [ipsl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic        [ipsl_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // Input word: one speed sample for one channel.
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic        [ipsl_pkg::CH_W-1:0]       in_channel,
  input  logic signed [ipsl_pkg::SPD_W-1:0]      in_target_speed,
  input  logic signed [ipsl_pkg::SPD_W-1:0]      in_measured_speed,
  // Output word: the new clamped drive of that channel.
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic        [ipsl_pkg::CH_W-1:0]       out_channel_out,
  output logic signed [ipsl_pkg::DRV_W-1:0]      out_drive
);
  import ipsl_pkg::*;

  // The controller walks each word through load, four multiplies, the divide,
  // the final subtraction and the clamp. The result sits in an output register,
  // so the next word can be accepted while the previous one waits to be taken.
  dp_cmd_t cmd;
  dp_sts_t sts;

  ipsl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // The datapath keeps the gains and limits, the per-channel error and
  // measurement history and the drive accumulators. The drive is forced to
  // zero for a zero target and then clamped high and low, the low limit last.
  ipsl_datapath #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_channel        (in_channel),
    .in_target_speed   (in_target_speed),
    .in_measured_speed (in_measured_speed),
    .cmd               (cmd),
    .sts               (sts),
    .out_channel_out   (out_channel_out),
    .out_drive         (out_drive)
  );

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the multi-channel incremental PID speed loop.
module testbench;
  import ipsl_pkg::*;

  // Indexes beyond the register map; the block must ignore writes to them.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  localparam int IDLE_PCT     = 19;   // chance in a hundred that a side idles in a cycle
  localparam int DRAIN_CYCLES = 60;   // a little more than the latency of one word
  localparam int MAX_REPORTS  = 10;
  localparam int RAND_PHASES  = 6;
  localparam int PHASE_WORDS  = 75;

  typedef struct packed {
    logic [CH_W-1:0]         channel;
    logic signed [DRV_W-1:0] drive;
  } drive_word_t;

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_we;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_DATA_W-1:0]      cfg_wdata;
  logic                       in_valid;
  logic                       in_ready;
  logic [CH_W-1:0]            in_channel;
  logic signed [SPD_W-1:0]    in_target_speed;
  logic signed [SPD_W-1:0]    in_measured_speed;
  logic                       out_valid;
  logic                       out_ready;
  logic [CH_W-1:0]            out_channel_out;
  logic signed [DRV_W-1:0]    out_drive;

  // Shadow copy of the register file, kept as wide signed numbers so the
  // loop arithmetic below is exact.
  longint kp, ki, kd, per_ms, lim_hi, lim_lo;

  // Per-channel loop history as seen by the predictor.
  longint last_err   [IPSL_CHANNELS];
  longint last_meas  [IPSL_CHANNELS];
  longint older_meas [IPSL_CHANNELS];
  longint drive_mem  [IPSL_CHANNELS];

  // Drive words the block still owes us, oldest first.
  drive_word_t pending_drives[$];
  drive_word_t head_word;

  int fail_count;
  bit steady_flow;   // when set, neither side idles

  incremental_pid_speed_loop_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_channel        (in_channel),
    .in_target_speed   (in_target_speed),
    .in_measured_speed (in_measured_speed),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_channel_out   (out_channel_out),
    .out_drive         (out_drive)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Load the register defaults and clear every channel, matching what the
  // block holds after reset.
  function automatic void load_defaults();
    kp     = longint'(GAIN_P_RST);
    ki     = longint'(GAIN_I_RST);
    kd     = longint'(GAIN_D_RST);
    per_ms = longint'(PERIOD_RST);
    lim_hi = longint'(LIMIT_HIGH_RST);
    lim_lo = longint'(LIMIT_LOW_RST);
    for (int c = 0; c < IPSL_CHANNELS; c++) begin
      last_err[c]   = 0;
      last_meas[c]  = 0;
      older_meas[c] = 0;
      drive_mem[c]  = 0;
    end
  endfunction

  // Mirror one register write; unknown indexes leave everything unchanged.
  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_GAIN_P:     kp     = longint'(data[GAIN_W-1:0]);
      REG_GAIN_I:     ki     = longint'(data[GAIN_W-1:0]);
      REG_GAIN_D:     kd     = longint'(data[GAIN_W-1:0]);
      REG_PERIOD:     per_ms = longint'(data[PER_W-1:0]);
      REG_LIMIT_HIGH: lim_hi = longint'($signed(data[DRV_W-1:0]));
      REG_LIMIT_LOW:  lim_lo = longint'($signed(data[DRV_W-1:0]));
      default: ;
    endcase
  endfunction

  // Velocity-form PID step for one channel. Gains are Q8.8 and the speeds are
  // integers, so every product already lands in Q.8 drive units. Only the
  // derivative division rounds, toward zero; a zero period drops that term.
  // A zero target forces the drive to zero before clamping, and the low
  // clamp is applied last so it wins when the limits are inverted.
  function automatic logic signed [DRV_W-1:0] next_drive(
      input logic [CH_W-1:0] ch,
      input logic signed [SPD_W-1:0] tgt,
      input logic signed [SPD_W-1:0] meas);
    longint err, p_term, i_term, d_term, acc;
    err    = longint'(tgt) - longint'(meas);
    p_term = kp * (err - last_err[ch]);
    i_term = ki * err * per_ms;
    d_term = 0;
    if (per_ms != 0) begin
      d_term = kd * (longint'(meas) - 2 * last_meas[ch] + older_meas[ch]) / per_ms;
    end
    acc = drive_mem[ch] + p_term + i_term - d_term;
    if (tgt == 0) begin
      acc = 0;
    end
    if (acc > lim_hi) begin
      acc = lim_hi;
    end
    if (acc < lim_lo) begin
      acc = lim_lo;
    end
    // The history moves on even when the drive was forced to zero.
    drive_mem[ch]  = acc;
    last_err[ch]   = err;
    older_meas[ch] = last_meas[ch];
    last_meas[ch]  = longint'(meas);
    return acc[DRV_W-1:0];
  endfunction

  // One register write. The strobe is high for a single cycle and is dropped before the task returns, so two writes
  // in a row never assign the enable twice in one time step.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    apply_reg(idx, data);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one speed sample and wait until the block takes it. The task returns
  // at the accepting edge with valid still high; the next call either drives
  // the following word in that same step or lowers valid for an idle gap, so
  // valid is never dropped and raised again within one step.
  task automatic send_sample(input logic [CH_W-1:0] ch,
                             input logic signed [SPD_W-1:0] tgt,
                             input logic signed [SPD_W-1:0] meas);
    drive_word_t w;
    if (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < IDLE_PCT);
    end
    in_valid          <= 1'b1;
    in_channel        <= ch;
    in_target_speed   <= tgt;
    in_measured_speed <= meas;
    do @(posedge clk); while (!in_ready);
    w.channel = ch;
    w.drive   = next_drive(ch, tgt, meas);
    pending_drives.push_back(w);
  endtask

  // Stop offering words and wait until every owed drive word has come back;
  // the loop is then idle and its registers may be rewritten.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_drives.size() != 0) @(posedge clk);
  endtask

  // A random sample. Most samples model a loop that is tracking, with the
  // measurement a little off the set point, some with a zero target or a target at
  // an end of its range; the rest are arbitrary or hold a measurement at an end of its range.
  task automatic random_sample();
    logic [CH_W-1:0]         ch;
    logic signed [SPD_W-1:0] t_raw;
    logic signed [SPD_W-1:0] m_raw;
    int pick, off, meas;
    ch    = CH_W'($urandom_range(0, IPSL_CHANNELS - 1));
    t_raw = SPD_W'($urandom);
    m_raw = SPD_W'($urandom);
    pick  = $urandom_range(0, 99);
    if (pick < 8) begin
      t_raw = '0;
    end else if (pick < 16) begin
      case ($urandom_range(0, 3))
        0: t_raw = 16'sh7FFF;
        1: t_raw = 16'sh8000;
        2: t_raw = 16'sd1;
        default: t_raw = -16'sd1;
      endcase
    end
    if (pick < 70) begin
      off  = $urandom_range(0, 600);
      meas = int'(t_raw) + off - 300;
      if (meas > 32767) begin
        meas = 32767;
      end
      if (meas < -32768) begin
        meas = -32768;
      end
      m_raw = meas[SPD_W-1:0];
    end else if (pick < 76) begin
      m_raw = ($urandom_range(0, 1) == 0) ? 16'sh7FFF : 16'sh8000;
    end
    send_sample(ch, t_raw, m_raw);
  endtask

  // New random settings for every register. Gains are mostly in a realistic
  // band, the limits are mostly ordered, and now and then the period is zero.
  task automatic random_settings();
    logic signed [DRV_W-1:0] la, lb, swap;
    int pick;
    pick = $urandom_range(0, 99);
    write_reg(REG_GAIN_P,
              CFG_DATA_W'((pick < 70) ? $urandom_range(0, 16'h3000) : $urandom));
    write_reg(REG_GAIN_I,
              CFG_DATA_W'((pick < 70) ? $urandom_range(0, 16'h0400) : $urandom));
    write_reg(REG_GAIN_D,
              CFG_DATA_W'((pick < 70) ? $urandom_range(0, 16'h1000) : $urandom));
    write_reg(REG_PERIOD,
              CFG_DATA_W'(($urandom_range(0, 99) < 8) ? 0 : $urandom_range(1, 255)));
    la   = DRV_W'($urandom);
    lb   = DRV_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      la = DRV_W'($urandom_range(0, 60000));
      lb = -$signed(24'($urandom_range(0, 60000)));
    end else if (pick < 80 && la < lb) begin
      swap = la;
      la   = lb;
      lb   = swap;
    end
    write_reg(REG_LIMIT_HIGH, la);
    write_reg(REG_LIMIT_LOW, lb);
  endtask

  // Reset defaults on every channel, zero target, and both speed fields
  // at the ends of their range.
  task automatic test_defaults();
    for (int c = 0; c < IPSL_CHANNELS; c++) begin
      send_sample(CH_W'(c), 16'sd1000, 16'sd0);
    end
    send_sample(2'd0, 16'sd0, 16'sd500);
    send_sample(2'd1, 16'sh7FFF, 16'sh8000);
    send_sample(2'd2, 16'sh8000, 16'sh7FFF);
    send_sample(2'd3, 16'sd100, 16'sd100);
  endtask

  // Largest gains with the shortest period and the widest limits push the
  // arithmetic as far as it goes; then all gains at zero must hold the drive,
  // and the longest period stretches the integral and shrinks the derivative.
  task automatic test_gain_extremes();
    wait_drained();
    write_reg(REG_GAIN_P, 24'h00FFFF);
    write_reg(REG_GAIN_I, 24'h00FFFF);
    write_reg(REG_GAIN_D, 24'h00FFFF);
    write_reg(REG_PERIOD, 24'd1);
    write_reg(REG_LIMIT_HIGH, 24'h7FFFFF);
    write_reg(REG_LIMIT_LOW, 24'h800000);
    send_sample(2'd0, 16'sh7FFF, 16'sh8000);
    send_sample(2'd0, 16'sh8000, 16'sh7FFF);
    send_sample(2'd1, -16'sd1, 16'sd0);
    send_sample(2'd2, 16'sd12000, 16'sd11990);
    wait_drained();
    write_reg(REG_GAIN_P, 24'd0);
    write_reg(REG_GAIN_I, 24'd0);
    write_reg(REG_GAIN_D, 24'd0);
    send_sample(2'd3, 16'sd500, 16'sd200);
    wait_drained();
    write_reg(REG_GAIN_P, 24'd2560);
    write_reg(REG_GAIN_I, 24'd128);
    write_reg(REG_GAIN_D, 24'd4096);
    write_reg(REG_PERIOD, 24'd255);
    send_sample(2'd1, 16'sd300, 16'sd250);
  endtask

  // With the low limit above the high limit every drive must come out at
  // the low limit, a zero target included.
  task automatic test_inverted_limits();
    wait_drained();
    write_reg(REG_LIMIT_HIGH, -24'sd1000);
    write_reg(REG_LIMIT_LOW, 24'sd2000);
    send_sample(2'd0, 16'sd5000, 16'sd0);
    send_sample(2'd1, 16'sd0, 16'sd0);
    send_sample(2'd2, -16'sd4000, 16'sd100);
  endtask

  // A zero period removes both the integral and the derivative terms, which
  // also shortens the latency of the block.
  task automatic test_zero_period();
    wait_drained();
    write_reg(REG_LIMIT_HIGH, 24'sd400000);
    write_reg(REG_LIMIT_LOW, -24'sd400000);
    write_reg(REG_PERIOD, 24'd0);
    send_sample(2'd0, 16'sd2000, 16'sd1500);
    send_sample(2'd1, -16'sd2000, 16'sd0);
    send_sample(2'd2, 16'sd0, 16'sd300);
    send_sample(2'd3, 16'sd1000, -16'sd1000);
  endtask

  // Writes to indexes past the register map must change nothing.
  task automatic test_spare_index();
    wait_drained();
    write_reg(REG_PERIOD, 24'd7);
    write_reg(REG_SPARE_6, 24'hFFFFFF);
    write_reg(REG_SPARE_7, 24'h000000);
    write_reg(REG_SPARE_6, 24'h000000);
    write_reg(REG_SPARE_7, 24'hFFFFFF);
    send_sample(2'd0, 16'sd100, 16'sd50);
    send_sample(2'd3, -16'sd100, 16'sd50);
  endtask

  // Random phases, each under fresh settings. One phase runs with both sides
  // always ready so the block is driven at its full rate.
  task automatic test_random_traffic();
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      wait_drained();
      random_settings();
      steady_flow = (ph == 3);
      repeat (PHASE_WORDS) random_sample();
    end
    wait_drained();
    steady_flow = 1'b0;
  endtask

  // The receiver stalls at random, except in the steady phase.
  always @(posedge clk) begin
    out_ready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Every drive word that leaves the block is matched against the oldest
  // prediction; extra words and wrong fields are failures.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_drives.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
          $display("unexpected word: channel %0d drive %0d", out_channel_out, out_drive);
        end
      end else begin
        head_word = pending_drives.pop_front();
        if (out_channel_out !== head_word.channel || out_drive !== head_word.drive) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("mismatch: expected channel %0d drive %0d, got channel %0d drive %0d",
                     head_word.channel, head_word.drive, out_channel_out, out_drive);
          end
        end
      end
    end
  end

  initial begin
    fail_count  = 0;
    steady_flow = 1'b0;
    load_defaults();
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= '0;
    cfg_wdata         <= '0;
    in_valid          <= 1'b0;
    in_channel        <= '0;
    in_target_speed   <= '0;
    in_measured_speed <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_defaults();
    test_gain_extremes();
    test_inverted_limits();
    test_zero_period();
    test_spare_index();
    test_random_traffic();

    // Give a stray extra word time to show up before the verdict.
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[incremental_pid_speed_loop_top] OK");
    end else begin
      $display("[incremental_pid_speed_loop_top] ERROR");
    end
    $finish;
  end

  // Watchdog: a normal run needs well under a tenth of this.
  initial begin
    #2000000;
    $display("[incremental_pid_speed_loop_top] ERROR");
    $finish;
  end

endmodule
